// File: design/binary_fraction_decimal_digit_generator_defines.svh
// Assertion macros shared by the checker of the decimal digit generator.
// Depends on nothing; the including scope supplies clk and rst.
`ifndef BINARY_FRACTION_DECIMAL_DIGIT_GENERATOR_DEFINES_SVH
`define BINARY_FRACTION_DECIMAL_DIGIT_GENERATOR_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define BFDG_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define BFDG_ASSERT_IMPLY(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) else $error(msg);

// Next-cycle implication.
`define BFDG_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

// File: design/bfdg_pkg.sv
// Shared types, codes and helpers of the decimal digit generator.
// No dependencies; imported by the MAC unit, the top level and the checker.
package bfdg_pkg;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  localparam logic [31:0] HALF_WORD = 32'h8000_0000;
  localparam logic [3:0]  MAX_DIGIT = 4'd9;

  typedef enum logic [1:0] {
    HALF_LESS    = 2'd0,
    HALF_EQUAL   = 2'd1,
    HALF_GREATER = 2'd2
  } half_cmp_t;

  // One word of the times-ten ripple: new word and carry into the next word.
  typedef struct packed {
    logic [3:0]  carry;
    logic [31:0] word;
  } mac_out_t;

  // Compare a fraction with one half from its top word and the OR of the rest.
  function automatic half_cmp_t half_of(logic [31:0] top, logic below_nz);
    half_cmp_t res;
    if (top < HALF_WORD) res = HALF_LESS;
    else if (top > HALF_WORD) res = HALF_GREATER;
    else if (below_nz) res = HALF_GREATER;
    else res = HALF_EQUAL;
    return res;
  endfunction

endpackage

// File: design/bfdg_word_ram.sv
// Fraction word store: one write port, one read port, registered read data.
// Depends on nothing.
module bfdg_word_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

endmodule

// File: design/bfdg_mac_unit.sv
// One word of the multiply-by-ten ripple: 10 * word + carry.
// Depends on bfdg_pkg for the result struct.
module bfdg_mac_unit
  import bfdg_pkg::*;
(
  input  logic [31:0] word_in,
  input  logic [3:0]  carry_in,
  output mac_out_t    result
);

  logic [35:0] wide;

  // times eight plus times two, then the incoming carry
  assign wide = ({4'd0, word_in} << 3) + ({4'd0, word_in} << 1) + {32'd0, carry_in};
  assign result.word  = wide[31:0];
  assign result.carry = wide[35:32];

endmodule

// File: design/binary_fraction_decimal_digit_generator.sv
// Exact binary fraction to decimal digits. The fraction below one lives in a word
// memory of WORD_COUNT 32-bit words; the top entry weighs 2^-32. A load item
// (kind 0) places significand after zero_count leading zero bits and writes two
// words, three when zero_count is not a multiple of 32, one memory write per word.
// A step item (kind 1) multiplies the fraction by ten and returns the carry out
// of the top as the next digit; it walks the live window one word per cycle
// through the single read port. A refused load or a step on an empty window goes
// straight to the result. Every result also reports whether the fraction is
// nonzero and how it compares with one half. A result waits in the output
// register while the next item is taken. The word memory needs no clearing: only
// words inside the window are ever used.
module binary_fraction_decimal_digit_generator
  import bfdg_pkg::*;
#(
  parameter int WORD_COUNT = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [63:0] significand,
  input  logic [11:0] zero_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  digit,
  output logic        remainder_nonzero,
  output logic [1:0]  half_compare,
  output logic        load_error
);

  localparam int IW = $clog2(WORD_COUNT + 1);
  localparam int AW = $clog2(WORD_COUNT);
  localparam int unsigned LOAD_LIMIT = 32 * (WORD_COUNT - 2);
  localparam logic [IW-1:0] TOP_INDEX = IW'(WORD_COUNT);

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD1, S_LOAD2, S_LOAD3, S_WALK, S_FIN, S_DONE
  } state_t;

  state_t state;

  // window [low, high) and status of the stored fraction
  logic [IW-1:0] low, high;
  logic          stat_nz;
  half_cmp_t     stat_half;

  // walk registers
  logic [IW-1:0] cur, low_w;
  logic [3:0]    carry;
  logic          trim, nz_acc, below_nz;
  logic [31:0]   top_t;

  // load registers
  logic [IW-1:0] ld_top;
  logic [31:0]   w_hi, w_mid, w_lo;
  logic          ld_three;

  // pending result
  logic [3:0] res_digit;
  logic       res_nz, res_err;
  half_cmp_t  res_half;

  // memory ports
  logic          wr_en;
  logic [IW-1:0] wr_idx, rd_idx;
  logic [31:0]   wr_data, rd_data;
  mac_out_t      mac;

  logic          accept, load_bad, last, grow, out_free;
  logic [95:0]   shifted;
  logic [IW-1:0] ld_top_c, cur_next;
  logic          ld_nz;
  half_cmp_t     ld_half, fin_half;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // load decode: refuse too many zeros, split the shifted significand into words
  assign load_bad = 32'(zero_count) > LOAD_LIMIT;
  assign shifted  = {significand, 32'd0} >> zero_count[4:0];
  assign ld_top_c = TOP_INDEX - IW'(zero_count[11:5]);
  assign ld_nz    = (significand != 64'd0);
  // only a load with no leading zeros puts a word at the top that can reach one half
  assign ld_half  = (zero_count == 12'd0) ?
                    half_of(significand[63:32], significand[31:0] != 32'd0) : HALF_LESS;

  // walk control
  assign cur_next = cur + IW'(1);
  assign last     = (cur_next == high);
  // a carry out of a window below the top becomes a new top word
  assign grow     = (carry != 4'd0) && (high != TOP_INDEX);
  assign fin_half = (!grow && high == TOP_INDEX && low_w < high) ?
                    half_of(top_t, below_nz) : HALF_LESS;

  assign rd_idx = (state == S_WALK) ? cur_next : low;

  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = cur;
    wr_data = mac.word;
    unique case (state)
      S_LOAD1: begin
        wr_en   = 1'b1;
        wr_idx  = ld_top - IW'(1);
        wr_data = w_hi;
      end
      S_LOAD2: begin
        wr_en   = 1'b1;
        wr_idx  = ld_top - IW'(2);
        wr_data = w_mid;
      end
      S_LOAD3: begin
        wr_en   = 1'b1;
        wr_idx  = ld_top - IW'(3);
        wr_data = w_lo;
      end
      S_WALK: begin
        // trimmed words are written too; they drop out of the window anyway
        wr_en = 1'b1;
      end
      S_FIN: begin
        wr_en   = grow;
        wr_idx  = high;
        wr_data = {28'd0, carry};
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  bfdg_word_ram #(
    .DEPTH (WORD_COUNT),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_idx[AW-1:0]),
    .wr_data (wr_data),
    .rd_addr (rd_idx[AW-1:0]),
    .rd_data (rd_data)
  );

  bfdg_mac_unit u_mac (
    .word_in  (rd_data),
    .carry_in (carry),
    .result   (mac)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      low       <= TOP_INDEX;
      high      <= TOP_INDEX;
      stat_nz   <= 1'b0;
      stat_half <= HALF_LESS;
      out_valid <= 1'b0;
    end else begin
      // drop the result once taken, unless the next one moves in right away
      if (out_valid && !out_stall && state != S_DONE) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            res_digit <= 4'd0;
            res_err   <= 1'b0;
            res_nz    <= stat_nz;
            res_half  <= stat_half;
            if (kind == KIND_LOAD) begin
              if (load_bad) begin
                // refuse: state untouched, report it as it stands
                res_err <= 1'b1;
                state   <= S_DONE;
              end else begin
                res_nz    <= ld_nz;
                res_half  <= ld_half;
                stat_nz   <= ld_nz;
                stat_half <= ld_half;
                high      <= ld_top_c;
                low       <= (zero_count[4:0] != 5'd0) ? ld_top_c - IW'(3)
                                                       : ld_top_c - IW'(2);
                ld_top    <= ld_top_c;
                ld_three  <= (zero_count[4:0] != 5'd0);
                w_hi      <= shifted[95:64];
                w_mid     <= shifted[63:32];
                w_lo      <= shifted[31:0];
                state     <= S_LOAD1;
              end
            end else if (low >= high) begin
              // empty window: nothing to multiply
              state <= S_DONE;
            end else begin
              // the read of the lowest word was issued this cycle
              cur    <= low;
              low_w  <= low;
              carry  <= 4'd0;
              trim   <= 1'b1;
              nz_acc <= 1'b0;
              state  <= S_WALK;
            end
          end
        end
        S_LOAD1: state <= S_LOAD2;
        S_LOAD2: state <= ld_three ? S_LOAD3 : S_DONE;
        S_LOAD3: state <= S_DONE;
        S_WALK: begin
          carry  <= mac.carry;
          nz_acc <= nz_acc | (mac.word != 32'd0);
          // advance the bottom past zero words while they keep coming
          if (trim && mac.word == 32'd0) low_w <= low_w + IW'(1);
          else trim <= 1'b0;
          if (last) begin
            top_t    <= mac.word;
            below_nz <= nz_acc;
            state    <= S_FIN;
          end else begin
            cur <= cur_next;
          end
        end
        S_FIN: begin
          low <= low_w;
          if (grow) high <= high + IW'(1);
          res_digit <= grow ? 4'd0 : carry;
          res_nz    <= nz_acc | grow;
          res_half  <= fin_half;
          stat_nz   <= nz_acc | grow;
          stat_half <= fin_half;
          state     <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid         <= 1'b1;
            digit             <= res_digit;
            remainder_nonzero <= res_nz;
            half_compare      <= res_half;
            load_error        <= res_err;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: design/bfdg_checker.sv
// Port-level checks of the decimal digit generator, bound to the top level.
// Depends on bfdg_pkg and the assertion macro header.
`include "binary_fraction_decimal_digit_generator_defines.svh"

module bfdg_checker
  import bfdg_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] digit,
  input logic       remainder_nonzero,
  input logic [1:0] half_compare,
  input logic       load_error
);

  `BFDG_ASSERT_HOLDS(a_digit_range, !out_valid || digit <= MAX_DIGIT, "digit above nine")
  `BFDG_ASSERT_IMPLY(a_err_no_digit, out_valid && load_error, digit == 4'd0, "digit on refused load")
  `BFDG_ASSERT_IMPLY(a_half_needs_nz, out_valid && half_compare != HALF_LESS, remainder_nonzero, "half without remainder")
  `BFDG_ASSERT_NEXT(a_stall_hold, out_valid && out_stall, out_valid && $stable(digit) && $stable(half_compare), "stalled item changed")

endmodule

bind binary_fraction_decimal_digit_generator bfdg_checker u_bfdg_checker (.*);
